// ===== sv/bbr_pkg.sv =====
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared types, constants and helpers for the 3x3 box blur with edge
// renormalization.
// ----------------------------------------------------------------------------
package bbr_pkg;

    // Configuration register fields
    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    localparam int DEFAULT_MAX_WIDTH  = 2048;
    localparam int DEFAULT_MAX_HEIGHT = 4096;

    // Sum of up to nine 8-bit samples, and the reciprocal used to divide it
    localparam int SAMPLE_W    = 8;
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } bbr_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MEM,
        ST_DIV
    } bbr_state_t;

    typedef struct packed {
        logic                cmd;
        logic [SAMPLE_W-1:0] in_red;
        logic [SAMPLE_W-1:0] in_green;
        logic [SAMPLE_W-1:0] in_blue;
    } bbr_in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] out_red;
        logic [SAMPLE_W-1:0] out_green;
        logic [SAMPLE_W-1:0] out_blue;
        logic                frame_end;
    } bbr_out_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
    } bbr_pixel_t;

    // One line store entry: two rows back, one row back
    typedef struct packed {
        bbr_pixel_t upper;
        bbr_pixel_t middle;
    } bbr_line_t;

    // Column entering the window: top, center and bottom row
    typedef struct packed {
        bbr_pixel_t upper;
        bbr_pixel_t middle;
        bbr_pixel_t lower;
    } bbr_column_t;

    // Which neighbors lie inside the frame
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } bbr_edge_t;

    typedef struct packed {
        logic [SUM_W-1:0]   red;
        logic [SUM_W-1:0]   green;
        logic [SUM_W-1:0]   blue;
        logic [RECIP_W-1:0] recip;
    } bbr_sum_t;

    // ceil(2^16 / count); exact after truncation for sums up to 9 * 255
    function automatic logic [RECIP_W-1:0] bbr_recip(input logic [1:0] rows,
                                                     input logic [1:0] cols);
        logic [3:0]         count;
        logic [RECIP_W-1:0] r;
        count = {2'b00, rows} * {2'b00, cols};
        unique case (count)
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd6:    r = 17'd10923;
            4'd9:    r = 17'd7282;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/bbr_line_buf.sv =====
// ----------------------------------------------------------------------------
// bbr_line_buf
// Line store: one entry per column holding the two previous rows.
// ----------------------------------------------------------------------------
module bbr_line_buf #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic               aclk,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output bbr_pkg::bbr_line_t rd_data,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  bbr_pkg::bbr_line_t wr_data
);
    import bbr_pkg::*;

    bbr_line_t line_mem [0:DEPTH-1];
    bbr_line_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/bbr_window.sv =====
// ----------------------------------------------------------------------------
// bbr_window
// Window columns and masked neighborhood sums with the matching reciprocal.
// ----------------------------------------------------------------------------
module bbr_window (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 shift_en,
    input  bbr_pkg::bbr_column_t col_new,
    input  bbr_pkg::bbr_edge_t   edges,
    output bbr_pkg::bbr_sum_t    sum
);
    import bbr_pkg::*;

    // [row][0] is the left column, [row][1] the center column
    bbr_pixel_t win_reg [0:2][0:1];
    bbr_pixel_t new_px  [0:2];
    logic [2:0] row_use;
    logic [1:0] rows;
    logic [1:0] cols;
    bbr_sum_t   sum_reg;
    bbr_sum_t   sum_next;

    assign new_px[0] = col_new.upper;
    assign new_px[1] = col_new.middle;
    assign new_px[2] = col_new.lower;
    assign row_use   = {edges.bottom, 1'b1, edges.top};
    assign rows      = 2'd1 + {1'b0, edges.top} + {1'b0, edges.bottom};
    assign cols      = 2'd1 + {1'b0, edges.left} + {1'b0, edges.right};

    always_comb begin
        sum_next.red   = '0;
        sum_next.green = '0;
        sum_next.blue  = '0;
        sum_next.recip = bbr_recip(rows, cols);
        for (int r = 0; r < 3; r++) begin
            if (row_use[r]) begin
                sum_next.red   = sum_next.red   + SUM_W'(win_reg[r][1].red);
                sum_next.green = sum_next.green + SUM_W'(win_reg[r][1].green);
                sum_next.blue  = sum_next.blue  + SUM_W'(win_reg[r][1].blue);
                if (edges.left) begin
                    sum_next.red   = sum_next.red   + SUM_W'(win_reg[r][0].red);
                    sum_next.green = sum_next.green + SUM_W'(win_reg[r][0].green);
                    sum_next.blue  = sum_next.blue  + SUM_W'(win_reg[r][0].blue);
                end
                if (edges.right) begin
                    sum_next.red   = sum_next.red   + SUM_W'(new_px[r].red);
                    sum_next.green = sum_next.green + SUM_W'(new_px[r].green);
                    sum_next.blue  = sum_next.blue  + SUM_W'(new_px[r].blue);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= '0;
                win_reg[r][1] <= '0;
            end
        end else if (shift_en) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= new_px[r];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// ===== sv/bbr_divide.sv =====
// ----------------------------------------------------------------------------
// bbr_divide
// Truncating divide of the three channel sums by reciprocal multiplication.
// ----------------------------------------------------------------------------
module bbr_divide (
    input  bbr_pkg::bbr_sum_t   sum,
    output bbr_pkg::bbr_pixel_t quot
);
    import bbr_pkg::*;

    localparam int PROD_W = SUM_W + RECIP_W;

    logic [PROD_W-1:0] prod_red;
    logic [PROD_W-1:0] prod_green;
    logic [PROD_W-1:0] prod_blue;

    assign prod_red   = PROD_W'(sum.red)   * PROD_W'(sum.recip);
    assign prod_green = PROD_W'(sum.green) * PROD_W'(sum.recip);
    assign prod_blue  = PROD_W'(sum.blue)  * PROD_W'(sum.recip);

    assign quot.red   = prod_red[RECIP_SHIFT +: SAMPLE_W];
    assign quot.green = prod_green[RECIP_SHIFT +: SAMPLE_W];
    assign quot.blue  = prod_blue[RECIP_SHIFT +: SAMPLE_W];

endmodule

// ===== sv/box_blur_3x3_edge_renorm.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_renorm
// Streaming 3x3 mean filter over RGB frames; only in-frame neighbors count.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                  | Carries
//  --------+----------------------------------------+---------------------------
//  input   | s_valid  s_ready  s_data               | pixel or drain, raster order
//  result  | m_valid  m_ready  m_data               | averaged pixel, frame_end
//  config  | cfg_valid cfg_ready cfg_index cfg_data | image_width / image_height
//
//  Each input transaction has three steps: accept and line store read, window
//  shift with line store write-back and neighborhood sum, then reciprocal
//  multiply into the output register. The line store read latency sets this.
//  A full output register stalls the third step until m_ready frees it.
//  Reset (aresetn low, synchronous) zeroes counters and window and loads
//  640 x 480; the line stores are not cleared, stale entries never reach a
//  result.
//
//  Results lag the input by one row plus one pixel; the host sends
//  width + 1 drain transactions after each frame to flush it.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_renorm #(
    parameter int MAX_WIDTH  = bbr_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = bbr_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  bbr_pkg::bbr_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output bbr_pkg::bbr_out_t                m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bbr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bbr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bbr_pkg::*;

    // Column counter indexes the line store; row counters hold up to height+1
    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WE_W   = $clog2(MAX_WIDTH + 1);
    localparam int HE_W   = $clog2(MAX_HEIGHT + 1);
    localparam int RIN_W  = $clog2(MAX_HEIGHT + 2);
    localparam int ROUT_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // Configuration
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic [WE_W-1:0]         w_eff;
    logic [HE_W-1:0]         h_eff;
    logic                    cfg_wr;
    logic                    cfg_hit;

    // Sequencer
    bbr_state_t state_reg;
    bbr_state_t state_next;
    logic       accept;
    logic       mem_stage;
    logic       load_out;

    // Position counters
    logic [COL_W-1:0]  in_col_reg;
    logic [COL_W-1:0]  in_col_next;
    logic [RIN_W-1:0]  in_row_reg;
    logic [RIN_W-1:0]  in_row_next;
    logic [COL_W-1:0]  out_col_reg;
    logic [COL_W-1:0]  out_col_next;
    logic [ROUT_W-1:0] out_row_reg;
    logic [ROUT_W-1:0] out_row_next;
    logic [WE_W-1:0]   in_col_inc;
    logic [WE_W-1:0]   out_col_inc;
    logic [HE_W-1:0]   out_row_inc;

    // Item datapath
    bbr_pixel_t  pix_reg;
    bbr_line_t   line_rd;
    bbr_line_t   line_wr;
    bbr_column_t col_new;
    bbr_edge_t   edges;
    bbr_sum_t    sum;
    bbr_pixel_t  quot;
    logic        emit;
    logic        last;
    logic        emit_reg;
    logic        last_reg;

    // Output register
    logic     m_valid_reg;
    bbr_out_t m_data_reg;

    // ------------------------------------------------------------------
    // Configuration registers. A write to image_width or image_height restarts
    // the frame (see counters). Out-of-range values are clamped where they are used.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_wr && ((cfg_index == REG_IMAGE_WIDTH)
                                  || (cfg_index == REG_IMAGE_HEIGHT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_WIDTH_W'(RESET_WIDTH);
            height_reg <= CFG_HEIGHT_W'(RESET_HEIGHT);
        end else if (cfg_wr) begin
            if (cfg_index == REG_IMAGE_WIDTH) begin
                width_reg <= cfg_data[CFG_WIDTH_W-1:0];
            end
            if (cfg_index == REG_IMAGE_HEIGHT) begin
                height_reg <= cfg_data[CFG_HEIGHT_W-1:0];
            end
        end
    end

    always_comb begin
        priority if (width_reg == '0) begin
            w_eff = WE_W'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = WE_W'(MAX_WIDTH);
        end else begin
            w_eff = WE_W'(width_reg);
        end
        priority if (height_reg == '0) begin
            h_eff = HE_W'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            h_eff = HE_W'(MAX_HEIGHT);
        end else begin
            h_eff = HE_W'(height_reg);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: IDLE accepts and starts the line store read, MEM does the
    // read-modify-write and sums, DIV loads the result register.
    // One item at a time, so a write-back always lands before the next read.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        mem_stage  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_MEM;
                end
            end
            ST_MEM: begin
                mem_stage  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!emit_reg) begin
                    state_next = ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    // Drain transactions enter as black pixels
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (s_data.cmd) begin
                pix_reg <= '0;
            end else begin
                pix_reg <= '{red: s_data.in_red, green: s_data.in_green,
                             blue: s_data.in_blue};
            end
        end
    end

    // ------------------------------------------------------------------
    // Line store: read at accept, write back {middle -> upper, new -> middle}
    // ------------------------------------------------------------------
    assign line_wr = '{upper: line_rd.middle, middle: pix_reg};

    bbr_line_buf #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (in_col_reg),
        .rd_data (line_rd),
        .wr_en   (mem_stage),
        .wr_addr (in_col_reg),
        .wr_data (line_wr)
    );

    // ------------------------------------------------------------------
    // Window and sums. The result pixel sits in the window's center column;
    // the right neighbor is the column now entering. At the start of a row
    // the result ends the previous row, so its right neighbor is off-frame
    // and the entering column is masked by the edge flags.
    // ------------------------------------------------------------------
    assign out_col_inc = WE_W'(out_col_reg) + WE_W'(1);
    assign out_row_inc = HE_W'(out_row_reg) + HE_W'(1);

    assign col_new      = '{upper: line_rd.upper, middle: line_rd.middle,
                            lower: pix_reg};
    assign edges.top    = (out_row_reg != '0);
    assign edges.bottom = (out_row_inc < h_eff);
    assign edges.left   = (out_col_reg != '0);
    assign edges.right  = (out_col_inc < w_eff);

    bbr_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (mem_stage),
        .col_new  (col_new),
        .edges    (edges),
        .sum      (sum)
    );

    bbr_divide u_divide (
        .sum  (sum),
        .quot (quot)
    );

    // ------------------------------------------------------------------
    // Position counters, advanced in the MEM cycle. Output starts once the
    // input is one row plus one pixel ahead; the last result of a frame
    // restarts all counters.
    // ------------------------------------------------------------------
    assign in_col_inc = WE_W'(in_col_reg) + WE_W'(1);
    assign emit = (in_row_reg >= RIN_W'(2))
               || ((in_row_reg == RIN_W'(1)) && (in_col_reg != '0));
    assign last = (out_row_inc >= h_eff) && (out_col_inc >= w_eff);

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_hit) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (mem_stage) begin
            if (in_col_inc >= w_eff) begin
                in_col_next = '0;
                in_row_next = in_row_reg + RIN_W'(1);
            end else begin
                in_col_next = in_col_inc[COL_W-1:0];
            end
            if (emit) begin
                if (last) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end else if (out_col_inc >= w_eff) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROUT_W'(1);
                end else begin
                    out_col_next = out_col_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            emit_reg    <= 1'b0;
            last_reg    <= 1'b0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            if (mem_stage) begin
                emit_reg <= emit;
                last_reg <= last;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds a finished result while the sink stalls.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= '{out_red: quot.red, out_green: quot.green,
                            out_blue: quot.blue, frame_end: last_reg};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
